@@ hw/rtl/assert_macros.svh @@
// Assertion helpers shared by the RTL; define ASSERT_OFF to drop them.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// expr must hold on every edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (expr)) else $error(msg);

// cons must hold in the same cycle as ante
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// cons must hold in the cycle after ante
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define ASSERT_ALWAYS(lbl, clk, rstn, expr, msg)
`define ASSERT_IMPLY(lbl, clk, rstn, ante, cons, msg)
`define ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg)

`endif

`endif

@@ hw/rtl/b64d_pkg.sv @@
package b64d_pkg;

    localparam logic [6:0] SEXTET_PAD = 7'd64;
    localparam logic [6:0] SEXTET_BAD = 7'd65;

    localparam logic [7:0] CH_UPPER_A = 8'h41;
    localparam logic [7:0] CH_UPPER_Z = 8'h5A;
    localparam logic [7:0] CH_LOWER_A = 8'h61;
    localparam logic [7:0] CH_LOWER_Z = 8'h7A;
    localparam logic [7:0] CH_DIGIT_0 = 8'h30;
    localparam logic [7:0] CH_DIGIT_9 = 8'h39;
    localparam logic [7:0] CH_PLUS    = 8'h2B;
    localparam logic [7:0] CH_SLASH   = 8'h2F;
    localparam logic [7:0] CH_EQUALS  = 8'h3D;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_BAD_CHAR = 2'd1,
        ST_BAD_LEN  = 2'd2,
        ST_OVER_CAP = 2'd3
    } t_status;

    // One queued request: up to three bytes, then optionally the status item.
    typedef struct packed {
        logic [23:0] word;
        logic [1:0]  nb;
        logic        is_last;
        t_status     status;
        logic [15:0] count;
    } t_job;

    function automatic logic [6:0] sextet_of(input logic [7:0] c);
        logic [6:0] v;
        v = SEXTET_BAD;
        if (c >= CH_UPPER_A && c <= CH_UPPER_Z) begin
            v = 7'(c - CH_UPPER_A);
        end else if (c >= CH_LOWER_A && c <= CH_LOWER_Z) begin
            v = 7'(c - CH_LOWER_A + 8'd26);
        end else if (c >= CH_DIGIT_0 && c <= CH_DIGIT_9) begin
            v = 7'(c - CH_DIGIT_0 + 8'd52);
        end else if (c == CH_PLUS) begin
            v = 7'd62;
        end else if (c == CH_SLASH) begin
            v = 7'd63;
        end else if (c == CH_EQUALS) begin
            v = SEXTET_PAD;
        end
        return v;
    endfunction

endpackage

@@ hw/rtl/base64_stream_decoder_top.sv @@
// Path: an accepted character updates the front end; any results it yields
// go as a request into the queue and are then registered by the back end.
// Throughput: one character per cycle in while the queue has room, one
// result per cycle out while i_ready allows; a quartet gives at most 3 bytes
// plus a status, absorbed by the request queue. Reset (i_rst_n, synchronous,
// active low) clears stream state and the queue and sets r_capacity to 65535.
module base64_stream_decoder_top #(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_char_in,
    input  logic        i_last_char,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_is_status,
    output logic [1:0]  o_status,
    output logic [15:0] o_byte_count,
    output logic        o_last_result,
    input  logic        i_cfg_we,
    input  logic [15:0] i_cfg_wdata
);

    logic [15:0]       r_capacity;
    logic              push, q_ready, q_valid, pop;
    b64d_pkg::t_job    f_job, q_job;
    b64d_pkg::t_status status;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity <= 16'hFFFF;
        end else if (i_cfg_we) begin
            r_capacity <= i_cfg_wdata;
        end
    end

    b64d_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_char_in     (i_char_in),
        .i_last_char   (i_last_char),
        .i_capacity    (r_capacity),
        .i_queue_ready (q_ready),
        .o_push        (push),
        .o_job         (f_job)
    );

    b64d_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_job   (f_job),
        .o_ready (q_ready),
        .i_pop   (pop),
        .o_valid (q_valid),
        .o_job   (q_job)
    );

    b64d_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_job_valid   (q_valid),
        .i_job         (q_job),
        .o_pop         (pop),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_out_byte    (o_out_byte),
        .o_is_status   (o_is_status),
        .o_status      (status),
        .o_byte_count  (o_byte_count),
        .o_last_result (o_last_result)
    );

    assign o_status = status;

endmodule

@@ hw/rtl/b64d_front.sv @@
`include "assert_macros.svh"

module b64d_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  logic [7:0]      i_char_in,
    input  logic            i_last_char,
    input  logic [15:0]     i_capacity,
    input  logic            i_queue_ready,
    output logic            o_push,
    output b64d_pkg::t_job  o_job
);

    logic [1:0]        r_pos,  n_pos;
    logic [17:0]       r_held, n_held;
    logic              r_pad,  n_pad;
    b64d_pkg::t_status r_err,  n_err;
    logic [15:0]       r_cnt,  n_cnt;

    logic [6:0]  sx;
    logic [23:0] word;
    logic [1:0]  nb;
    logic        emit;
    logic        acc;

    assign o_ready = i_queue_ready;
    assign acc     = i_valid && i_queue_ready;
    assign sx      = b64d_pkg::sextet_of(i_char_in);

    always_comb begin
        n_pos  = 2'(r_pos + 2'd1);
        n_held = r_held;
        n_pad  = r_pad;
        n_err  = r_err;
        n_cnt  = r_cnt;
        word   = '0;
        nb     = 2'd0;
        emit   = 1'b0;

        if (r_err == b64d_pkg::ST_OK) begin
            if (sx < b64d_pkg::SEXTET_PAD) begin
                if (r_pad) begin
                    n_err = b64d_pkg::ST_BAD_CHAR;
                end else if (r_pos != 2'd3) begin
                    n_held = {r_held[11:0], sx[5:0]};
                end else begin
                    word = {r_held, sx[5:0]};
                    nb   = 2'd3;
                end
            end else if (sx == b64d_pkg::SEXTET_PAD) begin
                if (r_pos == 2'd2) begin
                    n_pad  = 1'b1;
                    n_held = {r_held[11:0], 6'd0};
                end else if (r_pos == 2'd3 && i_last_char) begin
                    word = {r_held, 6'd0};
                    nb   = r_pad ? 2'd1 : 2'd2;
                end else begin
                    n_err = b64d_pkg::ST_BAD_CHAR;
                end
            end else begin
                n_err = b64d_pkg::ST_BAD_CHAR;
            end

            if (nb != 2'd0) begin
                // drop the whole quartet if it would pass the capacity
                if ({1'b0, r_cnt} + {15'd0, nb} > {1'b0, i_capacity}) begin
                    n_err = b64d_pkg::ST_OVER_CAP;
                end else begin
                    emit  = 1'b1;
                    n_cnt = 16'(r_cnt + {14'd0, nb});
                end
            end
        end

        if (r_pos == 2'd3) begin
            n_held = '0;
            n_pad  = 1'b0;
        end

        o_job.word    = word;
        o_job.nb      = emit ? nb : 2'd0;
        o_job.is_last = i_last_char;
        o_job.status  = (r_pos != 2'd3) ? b64d_pkg::ST_BAD_LEN : n_err;
        o_job.count   = n_cnt;

        if (i_last_char) begin
            n_pos  = 2'd0;
            n_held = '0;
            n_pad  = 1'b0;
            n_err  = b64d_pkg::ST_OK;
            n_cnt  = '0;
        end
    end

    assign o_push = acc && (emit || i_last_char);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos  <= '0;
            r_held <= '0;
            r_pad  <= 1'b0;
            r_err  <= b64d_pkg::ST_OK;
            r_cnt  <= '0;
        end else if (acc) begin
            r_pos  <= n_pos;
            r_held <= n_held;
            r_pad  <= n_pad;
            r_err  <= n_err;
            r_cnt  <= n_cnt;
        end
    end

    `ASSERT_NEXT(a_end_clears, i_clk, i_rst_n, acc && i_last_char,
        r_pos == 2'd0 && r_err == b64d_pkg::ST_OK && r_cnt == 16'd0,
        "stream state not cleared after last character")
    `ASSERT_NEXT(a_err_sticky, i_clk, i_rst_n,
        r_err != b64d_pkg::ST_OK && !(acc && i_last_char),
        r_err == $past(r_err), "sticky error changed inside a stream")
    `ASSERT_IMPLY(a_pad_place, i_clk, i_rst_n, r_pad,
        r_pos == 2'd3, "pad flag set outside the last quartet slot")

endmodule

@@ hw/rtl/b64d_queue.sv @@
`include "assert_macros.svh"

module b64d_queue #(
    parameter int DEPTH = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_push,
    input  b64d_pkg::t_job  i_job,
    output logic            o_ready,
    input  logic            i_pop,
    output logic            o_valid,
    output b64d_pkg::t_job  o_job
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    b64d_pkg::t_job r_mem [DEPTH];
    logic [AW-1:0]  r_wr, r_rd;
    logic [CW-1:0]  r_cnt;
    logic           do_push, do_pop;

    assign o_ready = (r_cnt != CW'(DEPTH));
    assign o_valid = (r_cnt != '0);
    assign o_job   = r_mem[r_rd];
    assign do_push = i_push && o_ready;
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_job;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : AW'(r_wr + 1'b1);
            end
            if (do_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : AW'(r_rd + 1'b1);
            end
            case ({do_push, do_pop})
                2'b10:   r_cnt <= CW'(r_cnt + 1'b1);
                2'b01:   r_cnt <= CW'(r_cnt - 1'b1);
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    `ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, i_push, o_ready,
        "request pushed into a full queue")

endmodule

@@ hw/rtl/b64d_back.sv @@
`include "assert_macros.svh"

module b64d_back (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_job_valid,
    input  b64d_pkg::t_job    i_job,
    output logic              o_pop,
    output logic              o_valid,
    input  logic              i_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_is_status,
    output b64d_pkg::t_status o_status,
    output logic [15:0]       o_byte_count,
    output logic              o_last_result
);

    logic [1:0] r_sel;
    logic       r_valid;
    logic       free, fire, stat_item, done;
    logic [7:0] sel_byte;

    assign free      = !r_valid || i_ready;
    assign fire      = free && i_job_valid;
    assign stat_item = (r_sel == i_job.nb);
    assign done      = stat_item || (2'(r_sel + 2'd1) == i_job.nb && !i_job.is_last);
    assign o_pop     = fire && done;
    assign o_valid   = r_valid;

    always_comb begin
        case (r_sel)
            2'd0:    sel_byte = i_job.word[23:16];
            2'd1:    sel_byte = i_job.word[15:8];
            2'd2:    sel_byte = i_job.word[7:0];
            default: sel_byte = 8'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_sel   <= '0;
        end else begin
            if (fire) begin
                r_valid <= 1'b1;
                r_sel   <= done ? 2'd0 : 2'(r_sel + 2'd1);
            end else if (i_ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (fire) begin
            o_out_byte    <= stat_item ? 8'd0 : sel_byte;
            o_is_status   <= stat_item;
            o_status      <= stat_item ? i_job.status : b64d_pkg::ST_OK;
            o_byte_count  <= stat_item ? i_job.count : 16'd0;
            o_last_result <= stat_item;
        end
    end

    `ASSERT_IMPLY(a_job_nonempty, i_clk, i_rst_n, i_job_valid,
        i_job.nb != 2'd0 || i_job.is_last, "queued request carries no result")
    `ASSERT_IMPLY(a_sel_range, i_clk, i_rst_n, i_job_valid,
        r_sel < i_job.nb || (r_sel == i_job.nb && i_job.is_last),
        "result index ran past the request")

endmodule
